[hw/rtl/tpc_pkg.sv]
// shared types and constants for the touch point conditioner
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int SMP_W     = 12;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int SIZE_W    = 13;
    localparam int ORIENT_W  = 3;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_CAL_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_CAL_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PR_THRESH  = 3'd7;

    // reset values of the registers
    localparam logic [SMP_W-1:0]    RST_X_CAL_LOW  = 12'd0;
    localparam logic [SMP_W-1:0]    RST_X_CAL_HIGH = 12'd4006;
    localparam logic [SMP_W-1:0]    RST_Y_CAL_LOW  = 12'd195;
    localparam logic [SMP_W-1:0]    RST_Y_CAL_HIGH = 12'd3803;
    localparam logic [SIZE_W-1:0]   RST_SCREEN_W   = 13'd480;
    localparam logic [SIZE_W-1:0]   RST_SCREEN_H   = 13'd320;
    localparam logic [ORIENT_W-1:0] RST_ORIENT     = 3'd3;
    localparam logic [SMP_W-1:0]    RST_PR_THRESH  = 12'd150;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;
    localparam logic [SMP_W-1:0]  VAL_MAX  = 12'hFFF;

    // orientation bits
    localparam int OR_SWAP  = 0;
    localparam int OR_INV_X = 1;
    localparam int OR_INV_Y = 2;

    typedef struct packed {
        logic             pen_down;
        logic [SMP_W-1:0] x_sample;
        logic [SMP_W-1:0] y_sample;
        logic [SMP_W-1:0] z1_sample;
        logic [SMP_W-1:0] z2_sample;
    } t_touch_in;

    typedef struct packed {
        logic             pressed;
        logic [SMP_W-1:0] screen_x;
        logic [SMP_W-1:0] screen_y;
        logic [SMP_W-1:0] median_x;
        logic [SMP_W-1:0] median_y;
        logic [SMP_W-1:0] pressure;
    } t_touch_out;

endpackage

`default_nettype wire

[hw/rtl/tpc_div.sv]
// bit-serial restoring divider, quotient known to fit in one sample width
`timescale 1ns / 1ps
`default_nettype none

module tpc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tpc_pkg::PROD_W-1:0]  i_dividend,
    input  logic [tpc_pkg::SMP_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [tpc_pkg::SMP_W-1:0]   o_quot
);
    import tpc_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SMP_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [SMP_W-1:0]  r_rem;
    logic [SMP_W-1:0]  r_acc;
    logic [SMP_W-1:0]  r_div;

    logic [SMP_W:0] trial;
    logic [SMP_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_acc[SMP_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:SMP_W];
            r_acc <= i_dividend[SMP_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[SMP_W-1:0] : trial[SMP_W-1:0];
            r_acc <= {r_acc[SMP_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

`default_nettype wire

[hw/rtl/touch_point_conditioner_core.sv]
// top level of the touch point conditioner: burst store, median scan, mapping and filter
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel (i_in_valid / o_in_ready / i_in_data): one transaction per
//   conversion pair; a pen-down transaction stores x and y in the burst store,
//   the one that completes a burst of SAMPLES also carries z1 and z2
// - output channel (o_out_valid / i_out_ready / o_out_data): at most one
//   transaction per input transaction, held in an output register
// - pen-up transaction: not-pressed result in the cycle after acceptance
// - burst still filling: no result, ready again the next cycle
// - completed burst with light pressure: not-pressed result in the cycle after acceptance
// - completed burst with real touch: median scan on one compare lane per
//   axis, a candidate load and a pass over the burst for each entry, then
//   per axis clamp, multiply, divider start, one divide step per quotient
//   bit and a done cycle, then a filter step that loads the result
// - one transaction in flight at a time; o_in_ready is high only with the
//   sequencer idle and the output register free or being emptied
// - a stalled receiver holds the result; the sequencer waits in its last step
// - reset (synchronous, active low) restores default calibration, empties
//   the burst, unseeds the filter and drops any pending result
// - configuration writes take effect at once and are meant for idle periods
module touch_point_conditioner_core #(
    parameter int SAMPLES = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tpc_pkg::t_touch_in             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output tpc_pkg::t_touch_out            o_out_data,
    input  logic                           i_cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tpc_pkg::CFG_W-1:0]      i_cfg_data
);
    import tpc_pkg::*;

    localparam int IW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CW = $clog2(SAMPLES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLES - 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(SAMPLES - 1);
    localparam logic [CW-1:0] MID_RANK = CW'(SAMPLES / 2);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADC = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIVS  = 3'd5;
    localparam logic [2:0] S_DIVW  = 3'd6;
    localparam logic [2:0] S_FILT  = 3'd7;

    // configuration
    logic [SMP_W-1:0]    r_xcl, r_xch, r_ycl, r_ych, r_thr;
    logic [SIZE_W-1:0]   r_scr_w, r_scr_h;
    logic [ORIENT_W-1:0] r_orient;

    // control
    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_i, r_j;
    logic [CW-1:0] r_ltx, r_lex, r_lty, r_ley;
    logic          r_axis;
    logic          r_sv;
    logic          r_out_valid;

    // datapath
    logic [SMP_W-1:0]  r_xbuf [SAMPLES];
    logic [SMP_W-1:0]  r_ybuf [SAMPLES];
    logic [SMP_W-1:0]  r_cx, r_cy, r_mx, r_my, r_pr;
    logic [SMP_W-1:0]  r_num, r_den, r_top, r_px, r_py;
    logic              r_zero, r_inv;
    logic [PROD_W-1:0] r_prod;
    logic [SMP_W-1:0]  r_sx, r_sy;
    t_touch_out        r_out;

    logic accept, out_free, burst_done, light, out_load;
    assign out_free = !r_out_valid || i_out_ready;
    assign accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign burst_done = (r_count == LAST_CNT);

    // pressure: z1 + (4095 - z2) never goes negative, only the top needs a clamp
    logic [SMP_W:0]   pr_sum;
    logic [SMP_W-1:0] n_pr;
    assign pr_sum = {1'b0, i_in_data.z1_sample} + {1'b0, ~i_in_data.z2_sample};
    assign n_pr   = pr_sum[SMP_W] ? VAL_MAX : pr_sum[SMP_W-1:0];
    assign light  = (n_pr < r_thr);

    // a result enters the output register: not-pressed at once, or after the filter
    assign out_load = (accept && (!i_in_data.pen_down || (burst_done && light))) ||
                      ((r_state == S_FILT) && out_free);

    // single read port into the burst store
    logic [IW-1:0]    rd_idx;
    logic [SMP_W-1:0] rd_x, rd_y;
    assign rd_idx = (r_state == S_LOADC) ? r_i : r_j;
    assign rd_x   = r_xbuf[rd_idx];
    assign rd_y   = r_ybuf[rd_idx];

    // rank counting against the candidate, one lane per axis
    logic [CW-1:0] n_ltx, n_lex, n_lty, n_ley;
    logic          hit_x, hit_y;
    assign n_ltx = r_ltx + CW'(rd_x <  r_cx);
    assign n_lex = r_lex + CW'(rd_x <= r_cx);
    assign n_lty = r_lty + CW'(rd_y <  r_cy);
    assign n_ley = r_ley + CW'(rd_y <= r_cy);
    assign hit_x = (n_ltx <= MID_RANK) && (n_lex > MID_RANK);
    assign hit_y = (n_lty <= MID_RANK) && (n_ley > MID_RANK);

    // axis set-up: clamp into the calibration range, either direction
    logic [SMP_W-1:0]  sel_v, sel_lo, sel_hi, v_c, n_num, n_den, n_top;
    logic [SIZE_W-1:0] sel_sz, sz_m1;
    logic              asc;
    assign sel_v  = (r_axis ^ r_orient[OR_SWAP]) ? r_my : r_mx;
    assign sel_lo = r_axis ? r_ycl : r_xcl;
    assign sel_hi = r_axis ? r_ych : r_xch;
    assign sel_sz = r_axis ? r_scr_h : r_scr_w;
    assign asc    = (sel_lo < sel_hi);
    assign sz_m1  = sel_sz - 1'b1;

    always_comb begin
        if (asc) begin
            if (sel_v < sel_lo)      v_c = sel_lo;
            else if (sel_v > sel_hi) v_c = sel_hi;
            else                     v_c = sel_v;
            n_num = v_c - sel_lo;
            n_den = sel_hi - sel_lo;
        end else begin
            if (sel_v > sel_lo)      v_c = sel_lo;
            else if (sel_v < sel_hi) v_c = sel_hi;
            else                     v_c = sel_v;
            n_num = sel_lo - v_c;
            n_den = sel_lo - sel_hi;
        end
        if (sel_sz == '0)          n_top = '0;
        else if (sel_sz > SIZE_MAX) n_top = VAL_MAX;
        else                        n_top = sz_m1[SMP_W-1:0];
    end

    // shared multiplier and divider
    logic [PROD_W-1:0] prod_c;
    logic              div_done;
    logic [SMP_W-1:0]  div_quot;
    logic [SMP_W-1:0]  q_c, p_c;
    assign prod_c = {{SMP_W{1'b0}}, r_num} * {{SMP_W{1'b0}}, r_top};
    assign q_c    = r_zero ? '0 : div_quot;
    assign p_c    = r_inv ? (r_top - q_c) : q_c;

    tpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIVS),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // halving filter
    logic [SMP_W:0] sum_x, sum_y;
    assign sum_x = {1'b0, r_sx} + {1'b0, r_px};
    assign sum_y = {1'b0, r_sy} + {1'b0, r_py};

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xcl    <= RST_X_CAL_LOW;
            r_xch    <= RST_X_CAL_HIGH;
            r_ycl    <= RST_Y_CAL_LOW;
            r_ych    <= RST_Y_CAL_HIGH;
            r_scr_w  <= RST_SCREEN_W;
            r_scr_h  <= RST_SCREEN_H;
            r_orient <= RST_ORIENT;
            r_thr    <= RST_PR_THRESH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_CAL_LOW:  r_xcl    <= i_cfg_data[SMP_W-1:0];
                REG_X_CAL_HIGH: r_xch    <= i_cfg_data[SMP_W-1:0];
                REG_Y_CAL_LOW:  r_ycl    <= i_cfg_data[SMP_W-1:0];
                REG_Y_CAL_HIGH: r_ych    <= i_cfg_data[SMP_W-1:0];
                REG_SCREEN_W:   r_scr_w  <= i_cfg_data[SIZE_W-1:0];
                REG_SCREEN_H:   r_scr_h  <= i_cfg_data[SIZE_W-1:0];
                REG_ORIENT:     r_orient <= i_cfg_data[ORIENT_W-1:0];
                REG_PR_THRESH:  r_thr    <= i_cfg_data[SMP_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_ltx       <= '0;
            r_lex       <= '0;
            r_lty       <= '0;
            r_ley       <= '0;
            r_axis      <= 1'b0;
            r_sv        <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load)                        r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!i_in_data.pen_down) begin
                            // pen up: empty burst, unseed filter
                            r_count     <= '0;
                            r_sv        <= 1'b0;
                            r_sx        <= '0;
                            r_sy        <= '0;
                        end else if (!burst_done) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_count <= '0;
                            if (light) begin
                                r_sv        <= 1'b0;
                                r_sx        <= '0;
                                r_sy        <= '0;
                            end else begin
                                r_i     <= '0;
                                r_state <= S_LOADC;
                            end
                        end
                    end
                end
                S_LOADC: begin
                    r_j     <= '0;
                    r_ltx   <= '0;
                    r_lex   <= '0;
                    r_lty   <= '0;
                    r_ley   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_ltx <= n_ltx;
                    r_lex <= n_lex;
                    r_lty <= n_lty;
                    r_ley <= n_ley;
                    if (r_j == LAST_IDX) begin
                        if (r_i == LAST_IDX) begin
                            r_axis  <= 1'b0;
                            r_state <= S_PREP;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_LOADC;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_PREP: r_state <= S_MUL;
                S_MUL:  r_state <= S_DIVS;
                S_DIVS: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_PREP;
                        end else begin
                            r_state <= S_FILT;
                        end
                    end
                end
                S_FILT: begin
                    if (out_free) begin
                        // first point after a press seeds the filter
                        r_sx        <= r_sv ? sum_x[SMP_W:1] : r_px;
                        r_sy        <= r_sv ? sum_y[SMP_W:1] : r_py;
                        r_sv        <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.pen_down) begin
            r_xbuf[r_count[IW-1:0]] <= i_in_data.x_sample;
            r_ybuf[r_count[IW-1:0]] <= i_in_data.y_sample;
            r_pr <= n_pr;
        end
        if (accept && (!i_in_data.pen_down || (burst_done && light))) begin
            r_out <= '0;
        end
        if (r_state == S_LOADC) begin
            r_cx <= rd_x;
            r_cy <= rd_y;
        end
        if (r_state == S_SCAN && r_j == LAST_IDX) begin
            if (hit_x) r_mx <= r_cx;
            if (hit_y) r_my <= r_cy;
        end
        if (r_state == S_PREP) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_top  <= n_top;
            r_zero <= (sel_lo == sel_hi);
            r_inv  <= r_axis ? r_orient[OR_INV_Y] : r_orient[OR_INV_X];
        end
        if (r_state == S_MUL) r_prod <= prod_c;
        if (r_state == S_DIVW && div_done) begin
            if (!r_axis) r_px <= p_c;
            else         r_py <= p_c;
        end
        if (r_state == S_FILT && out_free) begin
            r_out.pressed  <= 1'b1;
            r_out.screen_x <= r_sv ? sum_x[SMP_W:1] : r_px;
            r_out.screen_y <= r_sv ? sum_y[SMP_W:1] : r_py;
            r_out.median_x <= r_mx;
            r_out.median_y <= r_my;
            r_out.pressure <= r_pr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

[hw/rtl/tpc_checker.sv]
// port-level assertions for the touch point conditioner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module tpc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  tpc_pkg::t_touch_in             i_in_data,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  tpc_pkg::t_touch_out            o_out_data
);
    import tpc_pkg::*;

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // not-pressed results carry zeros
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pressed |->
            o_out_data.screen_x == '0 && o_out_data.screen_y == '0 &&
            o_out_data.median_x == '0 && o_out_data.median_y == '0 &&
            o_out_data.pressure == '0)
        else $error("not-pressed result with non-zero fields");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // pen-up transaction gives a not-pressed result in the next cycle
    a_pen_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.pen_down |=>
            o_out_valid && !o_out_data.pressed)
        else $error("pen-up transaction without not-pressed result");

endmodule

bind touch_point_conditioner_core tpc_checker u_tpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

[tb/sv/testbench.sv]
// self-checking testbench for the touch point conditioner core
`timescale 1ns / 1ps

module testbench;
    import tpc_pkg::*;

    localparam int N_SMP      = 5;
    localparam int IDLE_LIMIT = 3000;  // cycles with no transaction before giving up
    localparam int DRAIN_WAIT = 100;   // extra settle time once all queues are empty
    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 113;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    t_touch_in            in_data = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_touch_out           o_out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    touch_point_conditioner_core #(
        .SAMPLES(N_SMP)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // conversions waiting to be driven and touch points still owed by the block
    t_touch_in  sample_q[$];
    t_touch_out point_q[$];

    int  n_err    = 0;
    int  n_queued = 0;
    int  tx_gap   = 0;
    int  rx_wait  = 0;
    int  idle_cnt = 0;
    bit  calm     = 1'b0;  // no idling on either side while set
    bit  in_took  = 1'b0;
    bit  out_took = 1'b0;

    // predictor state: its own copy of the registers, burst store and filter
    logic [SMP_W-1:0]    cal_x_lo, cal_x_hi, cal_y_lo, cal_y_hi, press_min;
    logic [SIZE_W-1:0]   scr_w, scr_h;
    logic [ORIENT_W-1:0] orient;
    logic [SMP_W-1:0]    burst_xs [N_SMP];
    logic [SMP_W-1:0]    burst_ys [N_SMP];
    int unsigned         burst_fill;
    int unsigned         filt_x, filt_y;
    bit                  filt_seeded;

    bit                  pt_ready;
    t_touch_out          pt_next;
    t_touch_out          pt_want;

    task automatic reset_model();
        cal_x_lo    = RST_X_CAL_LOW;
        cal_x_hi    = RST_X_CAL_HIGH;
        cal_y_lo    = RST_Y_CAL_LOW;
        cal_y_hi    = RST_Y_CAL_HIGH;
        scr_w       = RST_SCREEN_W;
        scr_h       = RST_SCREEN_H;
        orient      = RST_ORIENT;
        press_min   = RST_PR_THRESH;
        burst_fill  = 0;
        filt_x      = 0;
        filt_y      = 0;
        filt_seeded = 1'b0;
        for (int i = 0; i < N_SMP; i++) begin
            burst_xs[i] = '0;
            burst_ys[i] = '0;
        end
    endtask

    // median by rank counting: the entry with at most N/2 below it and more than N/2 at or below
    function automatic logic [SMP_W-1:0] burst_median(input bit y_axis);
        int               lt, le;
        logic [SMP_W-1:0] v, w;
        for (int i = 0; i < N_SMP; i++) begin
            v  = y_axis ? burst_ys[i] : burst_xs[i];
            lt = 0;
            le = 0;
            for (int j = 0; j < N_SMP; j++) begin
                w = y_axis ? burst_ys[j] : burst_xs[j];
                if (w < v) lt++;
                if (w <= v) le++;
            end
            if (lt <= N_SMP / 2 && le > N_SMP / 2) return v;
        end
        return '0;
    endfunction

    // linear map of a raw value onto 0..top, reversed ranges count down from lo
    function automatic int unsigned map_axis(int unsigned v, int unsigned lo,
                                             int unsigned hi, int unsigned top);
        int unsigned num, den;
        if (lo == hi) return 0;
        if (lo < hi) begin
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            num = v - lo;
            den = hi - lo;
        end else begin
            if (v > lo) v = lo;
            if (v < hi) v = hi;
            num = lo - v;
            den = lo - hi;
        end
        return num * top / den;
    endfunction

    // out-of-range sizes are pulled into 1..4096
    function automatic int unsigned last_pixel(logic [SIZE_W-1:0] size);
        if (size < 1) return 0;
        if (size > SIZE_MAX) return int'(SIZE_MAX) - 1;
        return size - 1;
    endfunction

    // one accepted conversion in, at most one touch point out
    task automatic condition_point(input t_touch_in it, output bit has_pt,
                                   output t_touch_out pt);
        int               zsum;
        logic [SMP_W-1:0] pr, mx, my, sx, sy;
        int unsigned      tx, ty, px, py;
        pt     = '0;
        has_pt = 1'b1;
        if (!it.pen_down) begin
            burst_fill  = 0;
            filt_seeded = 1'b0;
            filt_x      = 0;
            filt_y      = 0;
            return;
        end
        if (burst_fill >= N_SMP) burst_fill = 0;
        burst_xs[burst_fill] = it.x_sample;
        burst_ys[burst_fill] = it.y_sample;
        burst_fill++;
        if (burst_fill < N_SMP) begin
            has_pt = 1'b0;
            return;
        end
        burst_fill = 0;

        zsum = int'(it.z1_sample) + int'(VAL_MAX) - int'(it.z2_sample);
        if (zsum < 0) zsum = 0;
        if (zsum > int'(VAL_MAX)) zsum = int'(VAL_MAX);
        pr = zsum[SMP_W-1:0];
        // light touch drops the filter seed
        if (pr < press_min) begin
            filt_seeded = 1'b0;
            filt_x      = 0;
            filt_y      = 0;
            return;
        end

        mx = burst_median(1'b0);
        my = burst_median(1'b1);
        sx = orient[OR_SWAP] ? my : mx;
        sy = orient[OR_SWAP] ? mx : my;
        tx = last_pixel(scr_w);
        ty = last_pixel(scr_h);
        px = map_axis(sx, cal_x_lo, cal_x_hi, tx);
        py = map_axis(sy, cal_y_lo, cal_y_hi, ty);
        if (orient[OR_INV_X]) px = tx - px;
        if (orient[OR_INV_Y]) py = ty - py;

        if (!filt_seeded) begin
            filt_x      = px;
            filt_y      = py;
            filt_seeded = 1'b1;
        end else begin
            filt_x = (filt_x + px) >> 1;
            filt_y = (filt_y + py) >> 1;
        end

        pt.pressed  = 1'b1;
        pt.screen_x = filt_x[SMP_W-1:0];
        pt.screen_y = filt_y[SMP_W-1:0];
        pt.median_x = mx;
        pt.median_y = my;
        pt.pressure = pr;
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        n_err++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // input side: record each accepted transaction and predict its touch point
    always @(posedge i_clk) begin
        in_took = i_rst_n && in_valid && o_in_ready;
        if (in_took) begin
            condition_point(in_data, pt_ready, pt_next);
            if (pt_ready) point_q.push_back(pt_next);
        end
    end

    // driver: one item per transaction, random gap after each acceptance
    always @(negedge i_clk) begin
        if (!in_valid || in_took) begin
            if (tx_gap > 0) begin
                tx_gap--;
                in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                in_data  <= sample_q.pop_front();
                in_valid <= 1'b1;
                tx_gap   = draw_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: holds ready low for a drawn number of cycles once a result is waiting
    always @(negedge i_clk) begin
        if (out_took) rx_wait = draw_gap();
        if (rx_wait > 0) begin
            out_ready <= 1'b0;
            if (o_out_valid) rx_wait--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: compare each result transaction with the oldest owed point
    always @(posedge i_clk) begin
        out_took = i_rst_n && o_out_valid && out_ready;
        if (out_took) begin
            if (point_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result pressed=%0d x=%0d y=%0d",
                                          o_out_data.pressed, o_out_data.screen_x,
                                          o_out_data.screen_y));
            end else begin
                pt_want = point_q.pop_front();
                check_field("pressed",  o_out_data.pressed,  pt_want.pressed);
                check_field("screen_x", o_out_data.screen_x, pt_want.screen_x);
                check_field("screen_y", o_out_data.screen_y, pt_want.screen_y);
                check_field("median_x", o_out_data.median_x, pt_want.median_x);
                check_field("median_y", o_out_data.median_y, pt_want.median_y);
                check_field("pressure", o_out_data.pressure, pt_want.pressure);
            end
        end
    end

    // watchdog: too long without any transaction or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we)
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cnt);
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic add_item(input bit pd, input int x, input int y, input int z1, input int z2);
        t_touch_in it;
        it.pen_down  = pd;
        it.x_sample  = x[SMP_W-1:0];
        it.y_sample  = y[SMP_W-1:0];
        it.z1_sample = z1[SMP_W-1:0];
        it.z2_sample = z2[SMP_W-1:0];
        sample_q.push_back(it);
        n_queued++;
    endtask

    task automatic add_pen_up();
        add_item(1'b0, $urandom, $urandom, $urandom, $urandom);
    endtask

    // mode 0 anywhere, 1 loose cluster, 2 rail values, 3 tight cluster
    function automatic int pick_sample(input int mode, input int centre);
        int v;
        case (mode)
            0:       v = $urandom_range(0, 4095);
            1:       v = centre + $urandom_range(0, 80) - 40;
            2:       v = $urandom_range(0, 1) ? 4095 : 0;
            default: v = centre + $urandom_range(0, 6) - 3;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // complete burst, pressure mostly above the current threshold
    task automatic add_burst();
        int mode, cx, cy, sel, pr, z1, z2;
        mode = $urandom_range(0, 3);
        cx   = $urandom_range(0, 4095);
        cy   = $urandom_range(0, 4095);
        for (int k = 0; k < N_SMP - 1; k++)
            add_item(1'b1, pick_sample(mode, cx), pick_sample(mode, cy), $urandom, $urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            z1 = $urandom_range(0, 4095);
            z2 = $urandom_range(0, 4095);
        end else begin
            if (sel == 1 && press_min > 0)
                pr = $urandom_range(0, int'(press_min) - 1);
            else
                pr = $urandom_range(int'(press_min), 4095);
            z2 = $urandom_range(4095 - pr, 4095);
            z1 = pr - 4095 + z2;
        end
        add_item(1'b1, pick_sample(mode, cx), pick_sample(mode, cy), z1, z2);
    endtask

    task automatic add_random_sequence();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            add_burst();
        end else if (kind < 80) begin
            add_pen_up();
        end else if (kind < 90) begin
            // burst cut short by a pen-up
            repeat ($urandom_range(1, N_SMP - 1))
                add_item(1'b1, $urandom, $urandom, $urandom, $urandom);
            add_pen_up();
        end else begin
            add_item($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_X_CAL_LOW:  cal_x_lo  = data[SMP_W-1:0];
            REG_X_CAL_HIGH: cal_x_hi  = data[SMP_W-1:0];
            REG_Y_CAL_LOW:  cal_y_lo  = data[SMP_W-1:0];
            REG_Y_CAL_HIGH: cal_y_hi  = data[SMP_W-1:0];
            REG_SCREEN_W:   scr_w     = data[SIZE_W-1:0];
            REG_SCREEN_H:   scr_h     = data[SIZE_W-1:0];
            REG_ORIENT:     orient    = data[ORIENT_W-1:0];
            REG_PR_THRESH:  press_min = data[SMP_W-1:0];
            default: ;
        endcase
    endtask

    // narrow registers get random spare top bits, which must be ignored
    task automatic set_all(input int xl, input int xh, input int yl, input int yh,
                           input int sw, input int sh, input int ori, input int th);
        write_reg(REG_X_CAL_LOW,  {1'($urandom), 12'(xl)});
        write_reg(REG_X_CAL_HIGH, {1'($urandom), 12'(xh)});
        write_reg(REG_Y_CAL_LOW,  {1'($urandom), 12'(yl)});
        write_reg(REG_Y_CAL_HIGH, {1'($urandom), 12'(yh)});
        write_reg(REG_SCREEN_W,   13'(sw));
        write_reg(REG_SCREEN_H,   13'(sh));
        write_reg(REG_ORIENT,     {10'($urandom), 3'(ori)});
        write_reg(REG_PR_THRESH,  {1'($urandom), 12'(th)});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_cal();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    function automatic int rand_size();
        case ($urandom_range(0, 9))
            0:       return 1;
            1:       return 4096;
            2:       return $urandom_range(0, 1) ? 8191 : 0;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // wait until every transaction is through, then let the block settle
    task automatic settle();
        while (sample_q.size() != 0 || in_valid || point_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        int stop_at;
        reset_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset calibration
        add_item(1'b0, 4095, 4095, 4095, 4095);              // pen up with all fields high
        repeat (N_SMP) add_item(1'b1, 0, 4095, 4095, 4095);
        sample_q[$].z2_sample = '0;                          // pressure clamps at the top
        repeat (N_SMP) add_item(1'b1, 4095, 0, 1000, 3000);  // filter averages with seed
        repeat (N_SMP) add_item(1'b1, 1234, 2345, 0, 4095);  // pressure is zero, light
        add_item(1'b1, 10, 3000, 0, 0);                      // pressure exactly at threshold
        add_item(1'b1, 4000, 100, 0, 0);
        add_item(1'b1, 2000, 3500, 0, 0);
        add_item(1'b1, 2001, 200, 0, 0);
        add_item(1'b1, 1999, 2500, 0, 4095 - int'(RST_PR_THRESH));
        add_item(1'b1, 7, 7, 7, 7);                          // burst broken by pen up
        add_item(1'b1, 8, 8, 8, 8);
        add_pen_up();
        settle();

        for (int p = 0; p < N_PHASES; p++) begin
            calm = (p % 3 == 1);
            case (p)
                0: set_all(0, 4095, 0, 4095, 4096, 4096, 0, 0);
                1: set_all(4095, 0, 4095, 0, 1, 1, 7, 4095);
                2: set_all(2000, 2000, 0, 0, 0, 8191, 5, $urandom_range(0, 4095));
                default: set_all(rand_cal(), rand_cal(), rand_cal(), rand_cal(),
                                 rand_size(), rand_size(), $urandom_range(0, 7),
                                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 600));
            endcase
            stop_at = n_queued + PHASE_LEN;
            while (n_queued < stop_at) add_random_sequence();
            settle();
        end

        if (n_err == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
